// ===== sv/smx_pkg.sv =====
// shared types and constants for the stack machine execute unit
package smx_pkg;

    localparam int StackDepth  = 256;
    localparam int NumRegs     = 16;
    localparam int ProgramSize = 4096;
    localparam int SpW         = $clog2(StackDepth + 1);
    localparam int SaW         = $clog2(StackDepth);
    localparam int RegW        = (NumRegs > 1) ? $clog2(NumRegs) : 1;
    localparam logic [15:0] ImmBytes  = 16'd4;
    localparam logic [15:0] JumpBytes = 16'd2;

    typedef enum logic [3:0] {
        OP_NOP   = 4'd0,
        OP_PUSH  = 4'd1,
        OP_POP   = 4'd2,
        OP_LOAD  = 4'd3,
        OP_STORE = 4'd4,
        OP_JMP   = 4'd5,
        OP_JZ    = 4'd6,
        OP_JNZ   = 4'd7,
        OP_ADD   = 4'd8,
        OP_SUB   = 4'd9,
        OP_MUL   = 4'd10,
        OP_DIV   = 4'd11,
        OP_PRINT = 4'd12,
        OP_STOP  = 4'd13
    } opcode_t;

    localparam logic [3:0] ST_OK        = 4'd0;
    localparam logic [3:0] ST_OVERFLOW  = 4'd1;
    localparam logic [3:0] ST_UNDERFLOW = 4'd2;
    localparam logic [3:0] ST_BAD_REG   = 4'd3;
    localparam logic [3:0] ST_BAD_JUMP  = 4'd4;
    localparam logic [3:0] ST_DIV_ZERO  = 4'd5;
    localparam logic [3:0] ST_INVALID   = 4'd6;
    localparam logic [3:0] ST_STOPPED   = 4'd7;
    localparam logic [3:0] ST_HALTED    = 4'd8;

    // classified instruction handed from front to back
    typedef struct packed {
        logic [3:0]  opcode;
        logic [31:0] push_value;
        logic        reg_ok;
        logic [RegW-1:0] reg_idx;
        logic        tgt_ok;
        logic [15:0] jump_target;
        logic [15:0] length;
    } instr_t;

    // result item
    typedef struct packed {
        logic [3:0]  status;
        logic [31:0] print_value;
        logic        print_valid;
        logic [15:0] next_ip;
    } result_t;

endpackage

// ===== sv/stack_machine_execute_unit.sv =====
// top level of the stack machine execute unit
//
// one decoded instruction enters per s_tvalid/s_tready transaction and one
// result leaves per m_tvalid/m_tready transaction, in order.
// a two-entry queue decouples the classifying front end from the executing
// back end, so the input keeps accepting while a result waits.
// nop, push, pop, load, jmp and stop are answered straight from S_IDLE;
// instructions that read the stack top (store, print, jz, jnz) wait on the
// registered read of the stack ram in S_RD1; add, sub, mul go on through
// S_RD2 and S_MUL; div waits in S_DIV on the one-bit-per-cycle divider.
// throughput is bounded by the single-port stack ram: one instruction at
// a time in the back end, so instructions answered straight from S_IDLE
// run at one per cycle while m_tready is high and the queue holds items.
// reset clears stack pointer, instruction pointer, halt flag and registers;
// stack contents are undefined until pushed.
// when m_tready is low the result holds and the back end waits; the queue
// fills and then s_tready drops.
// after any fault, stop or invalid opcode every item answers status halted.
module stack_machine_execute_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // opcode[3:0], push_value[35:4], reg_index[43:36], jump_target[59:44]
    input  logic [63:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // next_ip[15:0], print_valid[16], print_value[48:17], status[52:49]
    output logic [55:0] m_tdata
);
    import smx_pkg::*;

    logic    q_valid, q_pop;
    instr_t  q_data;
    result_t res;

    smx_front u_front (
        .clk(clk), .rst_n(rst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .s_tdata(s_tdata), .q_valid(q_valid), .q_pop(q_pop), .q_data(q_data)
    );

    smx_back u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_pop(q_pop),
        .q_data(q_data), .m_tvalid(m_tvalid), .m_tready(m_tready), .m_res(res)
    );

    assign m_tdata = {3'b000, res.status, res.print_value, res.print_valid,
                      res.next_ip};

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // no print value without print flag
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[16] |-> m_tdata[48:17] == 32'd0)
        else $error("print value without flag");

    // queue never pops empty
    assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("queue underrun");
endmodule

// ===== sv/smx_ram.sv =====
// generic single-port ram with registered read
module smx_ram #(
    parameter int Width = 32,
    parameter int Depth = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] addr,
    input  logic [Width-1:0]         wdata,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// ===== sv/smx_front.sv =====
// front end: accepts instructions, classifies them and queues them
module smx_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [63:0]     s_tdata,
    output logic            q_valid,
    input  logic            q_pop,
    output smx_pkg::instr_t q_data
);
    import smx_pkg::*;

    instr_t      cls;
    logic [3:0]  op;
    logic [7:0]  ri;
    logic [1:0]  cnt_reg, cnt_next;
    logic        rd_reg, rd_next, wr_reg, wr_next;
    instr_t      buf_reg [2];
    logic        push;

    assign op = s_tdata[3:0];
    assign ri = s_tdata[43:36];

    // decode the item
    always_comb
    begin
        cls.opcode      = op;
        cls.push_value  = s_tdata[35:4];
        cls.reg_ok      = (32'(ri) < 32'(NumRegs));
        cls.reg_idx     = RegW'(ri);
        cls.jump_target = s_tdata[59:44];
        cls.tgt_ok      = (32'(s_tdata[59:44]) < 32'(ProgramSize));
        case (op)
            OP_PUSH:                 cls.length = 16'd1 + ImmBytes;
            OP_LOAD, OP_STORE:       cls.length = 16'd2;
            OP_JMP, OP_JZ, OP_JNZ:   cls.length = 16'd1 + JumpBytes;
            default:                 cls.length = 16'd1;
        endcase
    end

    // two-entry queue
    assign s_tready = (cnt_reg != 2'd2);
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_data   = buf_reg[rd_reg];

    always_comb
    begin
        cnt_next = cnt_reg + 2'(push) - 2'(q_pop);
        rd_next  = rd_reg ^ q_pop;
        wr_next  = wr_reg ^ push;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            rd_reg  <= rd_next;
            wr_reg  <= wr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_reg[wr_reg] <= cls;
        end
    end
endmodule

// ===== sv/smx_div.sv =====
// iterative signed divider, one quotient bit per cycle
module smx_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [31:0] quotient
);
    import smx_pkg::*;

    logic [31:0] q_reg, q_next, d_reg, d_next;
    logic [32:0] r_reg, r_next, trial;
    logic [5:0]  n_reg, n_next;
    logic        neg_reg, neg_next, busy_reg, busy_next;

    always_comb
    begin
        q_next = q_reg; d_next = d_reg; r_next = r_reg;
        n_next = n_reg; neg_next = neg_reg; busy_next = busy_reg;
        trial  = {r_reg[31:0], q_reg[31]} - {1'b0, d_reg};
        done   = busy_reg && (n_reg == 6'd0);
        if (start)
        begin
            q_next    = dividend[31] ? (32'd0 - dividend) : dividend;
            d_next    = divisor[31] ? (32'd0 - divisor) : divisor;
            neg_next  = dividend[31] ^ divisor[31];
            r_next    = '0;
            n_next    = 6'd32;
            busy_next = 1'b1;
        end
        else if (busy_reg && n_reg != 6'd0)
        begin
            if (!trial[32])
            begin
                r_next = trial;
                q_next = {q_reg[30:0], 1'b1};
            end
            else
            begin
                r_next = {r_reg[31:0], q_reg[31]};
                q_next = {q_reg[30:0], 1'b0};
            end
            n_next = n_reg - 6'd1;
        end
        else if (done)
        begin
            busy_next = 1'b0;
        end
    end

    assign quotient = neg_reg ? (32'd0 - q_reg) : q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            n_reg    <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            n_reg    <= n_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        d_reg   <= d_next;
        r_reg   <= r_next;
        neg_reg <= neg_next;
    end
endmodule

// ===== sv/smx_back.sv =====
// back end: executes queued instructions against stack and registers
module smx_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    output logic             q_pop,
    input  smx_pkg::instr_t  q_data,
    output logic             m_tvalid,
    input  logic             m_tready,
    output smx_pkg::result_t m_res
);
    import smx_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_RD1, S_RD2, S_MUL, S_DIV, S_OUT
    } state_t;

    state_t      state_reg, state_next;
    instr_t      ins_reg, ins_next;
    logic [SpW-1:0] sp_reg, sp_next;
    logic [15:0] ip_reg, ip_next;
    logic        halt_reg, halt_next;
    logic [31:0] a_reg, a_next, p_reg, p_next;
    logic [31:0] regs_reg [NumRegs];
    logic [NumRegs-1:0] rwe;
    logic [31:0] rwd;
    result_t     res_reg, res_next;
    logic        ov_reg, ov_next;

    logic           st_we;
    logic [SaW-1:0] st_addr;
    logic [31:0]    st_wd, st_rd;
    logic           dv_start, dv_done;
    logic [31:0]    dv_q;

    smx_ram #(.Width(32), .Depth(StackDepth)) u_stack (
        .clk(clk), .we(st_we), .addr(st_addr), .wdata(st_wd), .rdata(st_rd)
    );

    smx_div u_div (
        .clk(clk), .rst_n(rst_n), .start(dv_start), .dividend(st_rd),
        .divisor(a_reg), .done(dv_done), .quotient(dv_q)
    );

    assign m_tvalid = ov_reg;
    assign m_res    = res_reg;

    // sequencer
    always_comb
    begin
        state_next = state_reg; ins_next = ins_reg; sp_next = sp_reg;
        ip_next = ip_reg; halt_next = halt_reg; a_next = a_reg; p_next = p_reg;
        res_next = res_reg; ov_next = ov_reg;
        st_we = 1'b0; st_addr = SaW'(sp_reg - SpW'(1)); st_wd = '0;
        rwe = '0; rwd = a_reg; dv_start = 1'b0; q_pop = 1'b0;
        if (ov_reg && m_tready)
        begin
            ov_next = 1'b0;
        end
        res_next.print_valid = 1'b0;
        res_next.print_value = '0;
        res_next.status      = ST_OK;
        res_next.next_ip     = ip_reg + ins_reg.length;
        case (state_reg)
            S_IDLE:
            begin
                if (q_valid && !ov_next)
                begin
                    q_pop    = 1'b1;
                    ins_next = q_data;
                    res_next.next_ip = ip_reg + q_data.length;
                    state_next = S_OUT;
                    if (halt_reg)
                    begin
                        res_next.status  = ST_HALTED;
                        res_next.next_ip = ip_reg;
                    end
                    else
                    begin
                        case (q_data.opcode)
                            OP_NOP: ;
                            OP_PUSH:
                                if (sp_reg == SpW'(StackDepth))
                                    res_next.status = ST_OVERFLOW;
                                else
                                begin
                                    st_we = 1'b1; st_addr = SaW'(sp_reg);
                                    st_wd = q_data.push_value;
                                    sp_next = sp_reg + SpW'(1);
                                end
                            OP_LOAD:
                                if (!q_data.reg_ok)
                                    res_next.status = ST_BAD_REG;
                                else if (sp_reg == SpW'(StackDepth))
                                    res_next.status = ST_OVERFLOW;
                                else
                                begin
                                    st_we = 1'b1; st_addr = SaW'(sp_reg);
                                    st_wd = regs_reg[q_data.reg_idx];
                                    sp_next = sp_reg + SpW'(1);
                                end
                            OP_STORE:
                                if (!q_data.reg_ok)
                                    res_next.status = ST_BAD_REG;
                                else if (sp_reg == '0)
                                    res_next.status = ST_UNDERFLOW;
                                else
                                begin
                                    sp_next = sp_reg - SpW'(1);
                                    state_next = S_RD1;
                                end
                            OP_JMP:
                                if (!q_data.tgt_ok)
                                    res_next.status = ST_BAD_JUMP;
                                else
                                    res_next.next_ip = q_data.jump_target;
                            OP_POP, OP_JZ, OP_JNZ, OP_PRINT, OP_ADD, OP_SUB,
                            OP_MUL, OP_DIV:
                                if (sp_reg == '0)
                                    res_next.status = ST_UNDERFLOW;
                                else
                                begin
                                    sp_next = sp_reg - SpW'(1);
                                    if (q_data.opcode != OP_POP)
                                        state_next = S_RD1;
                                end
                            OP_STOP:
                                res_next.status = ST_STOPPED;
                            default:
                                res_next.status = ST_INVALID;
                        endcase
                        if (res_next.status != ST_OK)
                        begin
                            halt_next = 1'b1;
                            res_next.next_ip = ip_reg;
                        end
                        else if (state_next == S_OUT)
                        begin
                            ip_next = res_next.next_ip;
                        end
                    end
                    if (state_next == S_OUT)
                    begin
                        ov_next = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        res_next = res_reg;
                    end
                end
                else
                begin
                    res_next = res_reg;
                end
            end
            S_RD1:
            begin
                // stack top is now on st_rd
                a_next = st_rd;
                state_next = S_OUT;
                case (ins_reg.opcode)
                    OP_STORE:
                    begin
                        rwe[ins_reg.reg_idx] = 1'b1;
                        rwd = st_rd;
                    end
                    OP_PRINT:
                    begin
                        res_next.print_valid = 1'b1;
                        res_next.print_value = st_rd;
                    end
                    OP_JZ, OP_JNZ:
                        if ((st_rd == '0) == (ins_reg.opcode == OP_JZ))
                        begin
                            if (!ins_reg.tgt_ok)
                                res_next.status = ST_BAD_JUMP;
                            else
                                res_next.next_ip = ins_reg.jump_target;
                        end
                    default:
                        if (ins_reg.opcode == OP_DIV && st_rd == '0)
                            res_next.status = ST_DIV_ZERO;
                        else if (sp_reg == '0)
                            res_next.status = ST_UNDERFLOW;
                        else
                        begin
                            sp_next = sp_reg - SpW'(1);
                            state_next = S_RD2;
                        end
                endcase
                if (state_next == S_OUT)
                begin
                    if (res_next.status != ST_OK)
                    begin
                        halt_next = 1'b1;
                        res_next.next_ip = ip_reg;
                    end
                    else
                    begin
                        ip_next = res_next.next_ip;
                    end
                    ov_next = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    res_next = res_reg;
                end
            end
            S_RD2:
            begin
                res_next = res_reg;
                case (ins_reg.opcode)
                    OP_ADD: begin p_next = st_rd + a_reg; state_next = S_MUL; end
                    OP_SUB: begin p_next = st_rd - a_reg; state_next = S_MUL; end
                    OP_MUL: begin p_next = st_rd * a_reg; state_next = S_MUL; end
                    default: begin dv_start = 1'b1; state_next = S_DIV; end
                endcase
            end
            S_DIV:
            begin
                res_next = res_reg;
                if (dv_done)
                begin
                    p_next = dv_q;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                // write the result back and report
                st_we = 1'b1; st_addr = SaW'(sp_reg); st_wd = p_reg;
                sp_next = sp_reg + SpW'(1);
                ip_next = res_next.next_ip;
                ov_next = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                res_next = res_reg;
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            sp_reg    <= '0;
            ip_reg    <= '0;
            halt_reg  <= 1'b0;
            ov_reg    <= 1'b0;
            for (int i = 0; i < NumRegs; i++)
                regs_reg[i] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            sp_reg    <= sp_next;
            ip_reg    <= ip_next;
            halt_reg  <= halt_next;
            ov_reg    <= ov_next;
            for (int i = 0; i < NumRegs; i++)
                if (rwe[i])
                    regs_reg[i] <= rwd;
        end
    end

    always_ff @(posedge clk)
    begin
        ins_reg <= ins_next;
        a_reg   <= a_next;
        p_reg   <= p_next;
        res_reg <= res_next;
    end
endmodule
